[hdl/kmpc_pkg.sv]
// shared types, register indices and timing constants for the key mode power controller
package kmpc_pkg;

    // field widths
    localparam int unsigned PRESS_W = 13;
    localparam int unsigned IDLE_W  = 15;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned SLOW_W  = 11;
    localparam int unsigned FAST_W  = 10;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    // press counter limits, one bit wider to hold the incremented value, and the idle counter cap
    localparam logic [PRESS_W:0]  LONG_PRESS_SET = 14'd6000;
    localparam logic [PRESS_W:0]  PRESS_CAP      = 14'd7000;
    localparam logic [IDLE_W-1:0] IDLE_CAP       = 15'd19531;

    // blink timing in ticks
    localparam logic [SLOW_W-1:0] SLOW_PERIOD_END = 11'd1704;
    localparam logic [SLOW_W-1:0] SLOW_ON_TICKS   = 11'd852;
    localparam logic [FAST_W-1:0] FAST_PERIOD_END = 10'd532;
    localparam logic [FAST_W-1:0] FAST_ON_TICKS   = 10'd266;

    // work modes
    localparam logic [MODE_W-1:0] MODE_ONE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TWO   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_THREE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FOUR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SLOW  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FAST  = 3'd6;

    // configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_PRESS_MIN  = 3'd0,
        REG_LONG_PRESS_TICKS = 3'd1,
        REG_RESELECT_WINDOW  = 3'd2,
        REG_DUTY_MODE_ONE    = 3'd3,
        REG_DUTY_MODE_TWO    = 3'd4,
        REG_DUTY_MODE_THREE  = 3'd5,
        REG_DUTY_MODE_FOUR   = 3'd6,
        REG_PULSE_DUTY       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PRESS_W-1:0] short_press_min;
        logic [PRESS_W-1:0] long_press_ticks;
        logic [IDLE_W-1:0]  reselect_window;
        logic [DUTY_W-1:0]  duty_mode_one;
        logic [DUTY_W-1:0]  duty_mode_two;
        logic [DUTY_W-1:0]  duty_mode_three;
        logic [DUTY_W-1:0]  duty_mode_four;
        logic [DUTY_W-1:0]  pulse_duty;
    } t_cfg;

    typedef struct packed {
        logic [PRESS_W-1:0] press_count;
        logic [IDLE_W-1:0]  idle_count;
        logic               power_on;
        logic [MODE_W-1:0]  work_mode;
        logic [SLOW_W-1:0]  slow_pulse_count;
        logic [FAST_W-1:0]  fast_pulse_count;
        logic [DUTY_W-1:0]  duty_level;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        short_press_min:  13'd118,
        long_press_ticks: 13'd5859,
        reselect_window:  15'd11719,
        duty_mode_one:    8'd128,
        duty_mode_two:    8'd64,
        duty_mode_three:  8'd26,
        duty_mode_four:   8'd6,
        pulse_duty:       8'd96
    };

    localparam t_state STATE_RESET = '{
        press_count:      '0,
        idle_count:       '0,
        power_on:         1'b0,
        work_mode:        MODE_ONE,
        slow_pulse_count: '0,
        fast_pulse_count: '0,
        duty_level:       '0
    };

endpackage

[hdl/kmpc_if.sv]
// request channel interfaces for ticks, results and configuration writes
interface kmpc_tick_if;
    logic valid;
    logic ready;
    logic key_pressed;
    logic charge_lock;
    logic sound_active;

    modport source (output valid, key_pressed, charge_lock, sound_active, input ready);
    modport sink   (input valid, key_pressed, charge_lock, sound_active, output ready);
endinterface

interface kmpc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       powered;
    logic [2:0] mode;
    logic       change_event;

    modport source (output valid, duty, powered, mode, change_event, input ready);
    modport sink   (input valid, duty, powered, mode, change_event, output ready);
endinterface

interface kmpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [14:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/kmpc_step.sv]
// next-state logic for one tick: key timing, power and mode, duty and blink
module kmpc_step
    import kmpc_pkg::*;
(
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  logic   i_key_pressed,
    input  logic   i_charge_lock,
    input  logic   i_sound_active,
    output t_state o_state,
    output logic   o_change
);

    logic [IDLE_W:0]  idle_inc;
    logic [PRESS_W:0] press_inc;
    logic [SLOW_W-1:0] slow_inc;
    logic [FAST_W-1:0] fast_inc;

    assign idle_inc  = {1'b0, i_state.idle_count} + 1'b1;
    assign slow_inc  = i_state.slow_pulse_count + 1'b1;
    assign fast_inc  = i_state.fast_pulse_count + 1'b1;

    always_comb begin
        o_state   = i_state;
        o_change  = 1'b0;
        press_inc = {1'b0, i_state.press_count} + 1'b1;

        if (!i_sound_active) begin
            // idle counter saturates
            if (idle_inc > {1'b0, IDLE_CAP}) begin
                o_state.idle_count = IDLE_CAP;
            end else begin
                o_state.idle_count = idle_inc[IDLE_W-1:0];
            end

            if (!i_charge_lock) begin
                if (i_key_pressed) begin
                    // long press forces power off
                    if (press_inc >= {1'b0, i_cfg.long_press_ticks} &&
                        press_inc < LONG_PRESS_SET) begin
                        o_state.power_on   = 1'b0;
                        o_state.work_mode  = MODE_ONE;
                        o_state.idle_count = '0;
                        press_inc          = LONG_PRESS_SET;
                        o_change           = 1'b1;
                    end
                    if (press_inc > PRESS_CAP) begin
                        o_state.press_count = PRESS_CAP[PRESS_W-1:0];
                    end else begin
                        o_state.press_count = press_inc[PRESS_W-1:0];
                    end
                end else begin
                    // short press on release
                    if (i_state.press_count > i_cfg.short_press_min &&
                        i_state.press_count < i_cfg.long_press_ticks) begin
                        if (!i_state.power_on) begin
                            o_state.power_on = 1'b1;
                        end else if (o_state.idle_count < i_cfg.reselect_window) begin
                            if (i_state.work_mode >= MODE_FAST) begin
                                o_state.work_mode = MODE_ONE;
                            end else begin
                                o_state.work_mode = i_state.work_mode + 1'b1;
                            end
                            o_change = 1'b1;
                        end else begin
                            o_state.power_on = 1'b0;
                            o_change         = 1'b1;
                        end
                        o_state.idle_count = '0;
                    end
                    o_state.press_count = '0;
                end
            end

            if (!o_state.power_on) begin
                o_state.duty_level = '0;
            end else begin
                case (o_state.work_mode)
                    MODE_ONE: begin
                        o_state.duty_level = i_cfg.duty_mode_one;
                    end
                    MODE_TWO: begin
                        o_state.duty_level = i_cfg.duty_mode_two;
                    end
                    MODE_THREE: begin
                        o_state.duty_level = i_cfg.duty_mode_three;
                    end
                    MODE_FOUR: begin
                        o_state.duty_level = i_cfg.duty_mode_four;
                    end
                    MODE_SLOW: begin
                        o_state.fast_pulse_count = '0;
                        if (slow_inc > SLOW_PERIOD_END) begin
                            o_state.slow_pulse_count = '0;
                        end else begin
                            o_state.slow_pulse_count = slow_inc;
                            o_state.duty_level = (slow_inc < SLOW_ON_TICKS) ?
                                                 i_cfg.pulse_duty : '0;
                        end
                    end
                    MODE_FAST: begin
                        o_state.slow_pulse_count = '0;
                        if (fast_inc > FAST_PERIOD_END) begin
                            o_state.fast_pulse_count = '0;
                        end else begin
                            o_state.fast_pulse_count = fast_inc;
                            o_state.duty_level = (fast_inc < FAST_ON_TICKS) ?
                                                 i_cfg.pulse_duty : '0;
                        end
                    end
                    default: begin
                        o_state.duty_level = i_state.duty_level;
                    end
                endcase
            end
        end
    end

endmodule

[hdl/key_mode_power_controller.sv]
// top level of the key mode power controller: state, configuration and result register
//
// usage
//   i_tick carries one 256 us tick per request: key level, charge lock and
//   sound-active flag. each accepted tick gives exactly one result on o_result:
//   duty level, power state, work mode and a one-tick change flag
//   i_cfg writes one of eight threshold and duty registers per request; it is
//   always ready and is meant to be used only while no result is outstanding
// timing
//   a tick is folded into the state in the cycle it is accepted, and its
//   result sits in the output register from the next cycle; a new tick can be
//   taken every cycle while the result side keeps up
// stalls
//   i_tick.ready stays high while the output register is empty or is being
//   emptied in the same cycle; while a result waits, further ticks are held off
// reset
//   synchronous, active low: state, configuration and result-valid registers return to
//   their default values, the device is off in mode 1 with all counters clear and no result pending
module key_mode_power_controller
    import kmpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmpc_tick_if.sink   i_tick,
    kmpc_result_if.source o_result,
    kmpc_cfg_if.sink    i_cfg
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   n_change;

    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_duty;
    logic              r_out_powered;
    logic [MODE_W-1:0] r_out_mode;
    logic              r_out_change;

    logic tick_take;

    // a tick may enter while the result register is free or draining
    assign i_tick.ready = !r_out_valid || o_result.ready;
    assign tick_take    = i_tick.valid && i_tick.ready;
    assign i_cfg.ready  = 1'b1;

    kmpc_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_key_pressed  (i_tick.key_pressed),
        .i_charge_lock  (i_tick.charge_lock),
        .i_sound_active (i_tick.sound_active),
        .o_state        (n_state),
        .o_change       (n_change)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_SHORT_PRESS_MIN:  r_cfg.short_press_min  <= i_cfg.data[PRESS_W-1:0];
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg.data[PRESS_W-1:0];
                REG_RESELECT_WINDOW:  r_cfg.reselect_window  <= i_cfg.data[IDLE_W-1:0];
                REG_DUTY_MODE_ONE:    r_cfg.duty_mode_one    <= i_cfg.data[DUTY_W-1:0];
                REG_DUTY_MODE_TWO:    r_cfg.duty_mode_two    <= i_cfg.data[DUTY_W-1:0];
                REG_DUTY_MODE_THREE:  r_cfg.duty_mode_three  <= i_cfg.data[DUTY_W-1:0];
                REG_DUTY_MODE_FOUR:   r_cfg.duty_mode_four   <= i_cfg.data[DUTY_W-1:0];
                REG_PULSE_DUTY:       r_cfg.pulse_duty       <= i_cfg.data[DUTY_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // controller state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (tick_take) begin
            r_state <= n_state;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, taken from the state just computed
    always_ff @(posedge i_clk) begin
        if (tick_take) begin
            r_out_duty    <= n_state.duty_level;
            r_out_powered <= n_state.power_on;
            r_out_mode    <= n_state.work_mode;
            r_out_change  <= n_change;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.duty         = r_out_duty;
    assign o_result.powered      = r_out_powered;
    assign o_result.mode         = r_out_mode;
    assign o_result.change_event = r_out_change;

endmodule

[dv/key_mode_power_controller_tb.sv]
// self-checking testbench for the key mode power controller: directed table, random key gestures, then a blink soak
module key_mode_power_controller_tb
    import kmpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one result as it leaves the block
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              powered;
        logic [MODE_W-1:0] mode;
        logic              change_event;
    } t_result;

    // shadow of the controller state, press counter one bit wider for the increment
    typedef struct {
        logic [PRESS_W:0]   press;
        logic [IDLE_W-1:0]  idle;
        logic               on;
        logic [MODE_W-1:0]  mode;
        logic [SLOW_W-1:0]  slow;
        logic [FAST_W-1:0]  fast;
        logic [DUTY_W-1:0]  duty;
    } t_ctl_state;

    // one row of the directed table: either a register write or a tick
    typedef struct {
        logic                  is_write;
        t_reg_idx              idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  key;
        logic                  lock;
        logic                  sound;
        logic                  typed;
        t_result               want;
    } t_step;

    // flavours of the random phases
    typedef enum {
        PH_LIVELY,
        PH_BURST,
        PH_WIDE,
        PH_NO_WINDOW,
        PH_BLINK
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    kmpc_tick_if   tick_ch();
    kmpc_result_if result_ch();
    kmpc_cfg_if    cfg_ch();

    key_mode_power_controller uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // predictor state and its copy of the registers
    t_ctl_state ctl;
    t_cfg       shadow_cfg;

    // results still owed by the block, oldest first
    t_result     pending_results[$];
    int unsigned error_count = 0;
    int unsigned ticks_sent  = 0;

    // idling switches, flipped per phase so that some stretches run flat out
    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("FAIL key_mode_power_controller");
        $finish;
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // count a failure, only the first ten get printed
    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    // idle length: mostly none, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 55)
            return 0;
        if (roll < 85)
            return int'($urandom_range(1, 3));
        if (roll < 98)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 40));
    endfunction

    // occasional lock or sound flag sprinkled into otherwise clean gestures
    function automatic logic stray();
        return $urandom_range(0, 23) == 0;
    endfunction

    // one tick through the controller: counters, key handling, then duty
    function automatic t_result advance_controller(logic key, logic lock, logic sound);
        t_result r;
        logic    change;
        change = 1'b0;
        if (!sound) begin
            // idle counter saturates
            if (ctl.idle < IDLE_CAP)
                ctl.idle = ctl.idle + 1'b1;
            if (!lock) begin
                if (key) begin
                    ctl.press = ctl.press + 1'b1;
                    // long hold: off, back to mode one, counter parks above the threshold
                    if (ctl.press >= shadow_cfg.long_press_ticks && ctl.press < LONG_PRESS_SET) begin
                        ctl.on    = 1'b0;
                        ctl.mode  = MODE_ONE;
                        ctl.press = LONG_PRESS_SET;
                        ctl.idle  = '0;
                        change    = 1'b1;
                    end
                    if (ctl.press > PRESS_CAP)
                        ctl.press = PRESS_CAP;
                end else begin
                    // release of a short press
                    if (ctl.press > shadow_cfg.short_press_min
                            && ctl.press < shadow_cfg.long_press_ticks) begin
                        if (!ctl.on) begin
                            ctl.on = 1'b1;
                        end else if (ctl.idle < shadow_cfg.reselect_window) begin
                            ctl.mode = (ctl.mode == MODE_FAST) ? MODE_ONE : ctl.mode + 1'b1;
                            change   = 1'b1;
                        end else begin
                            ctl.on = 1'b0;
                            change = 1'b1;
                        end
                        ctl.idle = '0;
                    end
                    ctl.press = '0;
                end
            end
            // duty follows the mode, blink counters only run while powered
            if (!ctl.on) begin
                ctl.duty = '0;
            end else begin
                case (ctl.mode)
                    MODE_ONE:   ctl.duty = shadow_cfg.duty_mode_one;
                    MODE_TWO:   ctl.duty = shadow_cfg.duty_mode_two;
                    MODE_THREE: ctl.duty = shadow_cfg.duty_mode_three;
                    MODE_FOUR:  ctl.duty = shadow_cfg.duty_mode_four;
                    MODE_SLOW: begin
                        ctl.fast = '0;
                        ctl.slow = ctl.slow + 1'b1;
                        // on the wrap tick the duty keeps its old value
                        if (ctl.slow > SLOW_PERIOD_END)
                            ctl.slow = '0;
                        else
                            ctl.duty = (ctl.slow < SLOW_ON_TICKS) ? shadow_cfg.pulse_duty : '0;
                    end
                    MODE_FAST: begin
                        ctl.slow = '0;
                        ctl.fast = ctl.fast + 1'b1;
                        if (ctl.fast > FAST_PERIOD_END)
                            ctl.fast = '0;
                        else
                            ctl.duty = (ctl.fast < FAST_ON_TICKS) ? shadow_cfg.pulse_duty : '0;
                    end
                    default: ;
                endcase
            end
        end
        r.duty         = ctl.duty;
        r.powered      = ctl.on;
        r.mode         = ctl.mode;
        r.change_event = change;
        return r;
    endfunction

    // register settings for one random phase
    function automatic t_cfg phase_settings(t_phase kind);
        t_cfg s;
        s.short_press_min  = 13'($urandom_range(0, 4));
        s.long_press_ticks = s.short_press_min + 13'($urandom_range(2, 24));
        s.reselect_window  = 15'($urandom_range(4, 90));
        s.duty_mode_one    = 8'($urandom_range(0, 255));
        s.duty_mode_two    = 8'($urandom_range(0, 255));
        s.duty_mode_three  = 8'($urandom_range(0, 255));
        s.duty_mode_four   = 8'($urandom_range(0, 255));
        s.pulse_duty       = 8'($urandom_range(0, 255));
        case (kind)
            PH_WIDE: begin
                // widest thresholds, duties at the rails
                s.short_press_min  = '0;
                s.long_press_ticks = 13'd5999;
                s.reselect_window  = IDLE_CAP;
                s.duty_mode_one    = 8'd255;
                s.duty_mode_two    = 8'd0;
                s.duty_mode_three  = 8'd255;
                s.duty_mode_four   = 8'd0;
                s.pulse_duty       = 8'd255;
            end
            PH_NO_WINDOW: s.reselect_window = '0;
            PH_BLINK: begin
                // quick presses, every press while on steps the mode
                s.short_press_min  = 13'd1;
                s.long_press_ticks = 13'd8;
                s.reselect_window  = IDLE_CAP;
                s.pulse_duty       = 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_step tick_row(logic k, logic l, logic s);
        t_step r;
        r          = '{default: '0, idx: REG_SHORT_PRESS_MIN};
        r.key      = k;
        r.lock     = l;
        r.sound    = s;
        return r;
    endfunction

    function automatic t_step checked_row(logic k, logic l, logic s, logic [DUTY_W-1:0] d,
                                          logic p, logic [MODE_W-1:0] m, logic c);
        t_step r;
        r       = tick_row(k, l, s);
        r.typed = 1'b1;
        r.want  = '{duty: d, powered: p, mode: m, change_event: c};
        return r;
    endfunction

    function automatic t_step reg_row(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        t_step r;
        r          = tick_row(1'b0, 1'b0, 1'b0);
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one tick, wait for the request to be taken, log what must come back
    task automatic send_tick(input logic key, input logic lock, input logic sound,
                             input logic typed = 1'b0, input t_result want = '0);
        t_result predicted;
        int      gap;
        cfg_ch.valid         <= 1'b0;
        tick_ch.valid        <= 1'b1;
        tick_ch.key_pressed  <= key;
        tick_ch.charge_lock  <= lock;
        tick_ch.sound_active <= sound;
        do @(posedge i_clk); while (!(tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1));
        predicted = advance_controller(key, lock, sound);
        pending_results.push_back(typed ? want : predicted);
        ticks_sent++;
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every owed result is back, then a short pause
    task automatic settle();
        tick_ch.valid <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // one register write request; valid is dropped by the next tick or settle
    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
        case (idx)
            REG_SHORT_PRESS_MIN:  shadow_cfg.short_press_min  = value[PRESS_W-1:0];
            REG_LONG_PRESS_TICKS: shadow_cfg.long_press_ticks = value[PRESS_W-1:0];
            REG_RESELECT_WINDOW:  shadow_cfg.reselect_window  = value[IDLE_W-1:0];
            REG_DUTY_MODE_ONE:    shadow_cfg.duty_mode_one    = value[DUTY_W-1:0];
            REG_DUTY_MODE_TWO:    shadow_cfg.duty_mode_two    = value[DUTY_W-1:0];
            REG_DUTY_MODE_THREE:  shadow_cfg.duty_mode_three  = value[DUTY_W-1:0];
            REG_DUTY_MODE_FOUR:   shadow_cfg.duty_mode_four   = value[DUTY_W-1:0];
            REG_PULSE_DUTY:       shadow_cfg.pulse_duty       = value[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // all eight registers, back to back
    task automatic write_settings(t_cfg s);
        write_reg(REG_SHORT_PRESS_MIN,  CFG_DATA_W'(s.short_press_min));
        write_reg(REG_LONG_PRESS_TICKS, CFG_DATA_W'(s.long_press_ticks));
        write_reg(REG_RESELECT_WINDOW,  CFG_DATA_W'(s.reselect_window));
        write_reg(REG_DUTY_MODE_ONE,    CFG_DATA_W'(s.duty_mode_one));
        write_reg(REG_DUTY_MODE_TWO,    CFG_DATA_W'(s.duty_mode_two));
        write_reg(REG_DUTY_MODE_THREE,  CFG_DATA_W'(s.duty_mode_three));
        write_reg(REG_DUTY_MODE_FOUR,   CFG_DATA_W'(s.duty_mode_four));
        write_reg(REG_PULSE_DUTY,       CFG_DATA_W'(s.pulse_duty));
    endtask

    // one key gesture: a hold of some length, then a release stretch;
    // mostly clean short presses, some long holds, some too short, some noise
    task automatic key_gesture();
        int spm;
        int lpt;
        int rw;
        int hold;
        int rest;
        int pick;
        spm = int'(shadow_cfg.short_press_min);
        lpt = int'(shadow_cfg.long_press_ticks);
        rw  = int'(shadow_cfg.reselect_window);
        // now and then drain completely in mid phase
        if ($urandom_range(0, 39) == 0)
            settle();
        pick = int'($urandom_range(0, 9));
        if (pick == 9) begin
            repeat ($urandom_range(1, 6))
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            return;
        end
        // hold length
        if (pick == 7 && lpt <= 60) begin
            hold = int'($urandom_range(lpt > 0 ? lpt : 1, lpt + 12));
        end else if (pick == 8) begin
            hold = int'($urandom_range(1, spm + 1));
        end else if (lpt - 1 < spm + 1) begin
            hold = int'($urandom_range(1, 8));
        end else begin
            hold = int'($urandom_range(spm + 1, (lpt - 1 < spm + 31) ? lpt - 1 : spm + 31));
        end
        // release stretch: inside the reselect window, or past it where that is short
        if ($urandom_range(0, 9) < 8 || rw > 100)
            rest = int'($urandom_range(1, (rw / 2 < 30) ? rw / 2 + 1 : 31));
        else
            rest = int'($urandom_range(rw + 1, rw + 16));
        repeat (hold) send_tick(1'b1, stray(), stray());
        repeat (rest) send_tick(1'b0, stray(), stray());
    endtask

    // quick presses until the device is on in the wanted mode
    task automatic steer_to(logic [MODE_W-1:0] target);
        while (!(ctl.on && ctl.mode == target)) begin
            repeat (2) send_tick(1'b1, 1'b0, 1'b0);
            send_tick(1'b0, 1'b0, 1'b0);
        end
    endtask

    // sit in the current mode; locked key presses and rare sound ticks mixed in
    task automatic dwell(int count);
        logic lock;
        repeat (count) begin
            lock = $urandom_range(0, 7) == 0;
            send_tick(lock & 1'($urandom_range(0, 1)), lock, $urandom_range(0, 31) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and in-order comparison
    // ------------------------------------------------------------------
    initial begin : result_sink
        int      stall_left;
        int      g;
        t_result got;
        t_result want;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got = '{duty: result_ch.duty, powered: result_ch.powered,
                        mode: result_ch.mode, change_event: result_ch.change_event};
                if (pending_results.size() == 0) begin
                    note_failure($sformatf(
                        "result with nothing outstanding: duty %0d powered %0b mode %0d change %0b",
                        got.duty, got.powered, got.mode, got.change_event));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"result mismatch: expected duty %0d powered %0b ",
                            "mode %0d change %0b, got duty %0d powered %0b mode %0d change %0b"},
                            want.duty, want.powered, want.mode, want.change_event,
                            got.duty, got.powered, got.mode, got.change_event));
                end
            end
            // next cycle's ready
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (sink_stalls) begin
                g = pick_gap();
                if (g == 0) begin
                    result_ch.ready <= 1'b1;
                end else begin
                    stall_left = g - 1;
                    result_ch.ready <= 1'b0;
                end
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_step  directed[$];
        t_phase plan[4];
        int     phase_end;
        logic   prev_write;

        // everything known from time zero, while reset is held
        i_rst_n              <= 1'b0;
        tick_ch.valid        <= 1'b0;
        tick_ch.key_pressed  <= 1'b0;
        tick_ch.charge_lock  <= 1'b0;
        tick_ch.sound_active <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_SHORT_PRESS_MIN;
        cfg_ch.data          <= '0;

        ctl        = '{press: '0, idle: '0, on: 1'b0, mode: MODE_ONE,
                       slow: '0, fast: '0, duty: '0};
        shadow_cfg = CFG_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: reset values, lock and sound, power on without a change flag,
        // step inside the window, long hold, threshold extremes, late press switching off
        directed = '{
            checked_row(1'b1, 1'b0, 1'b1, 8'd0,   1'b0, MODE_ONE, 1'b0), // sound right after reset
            checked_row(1'b1, 1'b1, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0), // key frozen by charging
            checked_row(1'b1, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0),
            checked_row(1'b0, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0), // far too short
            reg_row(REG_SHORT_PRESS_MIN, 15'd0),
            reg_row(REG_LONG_PRESS_TICKS, 15'd2),
            reg_row(REG_DUTY_MODE_ONE, 15'd255),
            checked_row(1'b1, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0),
            checked_row(1'b0, 1'b0, 1'b0, 8'd255, 1'b1, MODE_ONE, 1'b0), // on, no change flag
            tick_row(1'b1, 1'b0, 1'b0),
            checked_row(1'b0, 1'b0, 1'b0, 8'd64,  1'b1, MODE_TWO, 1'b1), // step, default duty
            checked_row(1'b1, 1'b0, 1'b1, 8'd64,  1'b1, MODE_TWO, 1'b0), // sound holds all
            tick_row(1'b1, 1'b1, 1'b0),
            tick_row(1'b0, 1'b1, 1'b0),
            tick_row(1'b1, 1'b0, 1'b0),
            checked_row(1'b1, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b1), // long hold
            checked_row(1'b1, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0), // keeps counting
            checked_row(1'b0, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0),
            reg_row(REG_LONG_PRESS_TICKS, 15'd0),
            checked_row(1'b1, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b1), // zero threshold
            tick_row(1'b0, 1'b0, 1'b0),
            reg_row(REG_LONG_PRESS_TICKS, 15'd5999),
            reg_row(REG_RESELECT_WINDOW, 15'd0),
            tick_row(1'b1, 1'b0, 1'b0),
            checked_row(1'b0, 1'b0, 1'b0, 8'd255, 1'b1, MODE_ONE, 1'b0),
            tick_row(1'b1, 1'b0, 1'b0),
            checked_row(1'b0, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b1), // outside the window
            reg_row(REG_RESELECT_WINDOW, 15'd19531),
            reg_row(REG_SHORT_PRESS_MIN, 15'd8191),
            tick_row(1'b1, 1'b0, 1'b0),
            checked_row(1'b0, 1'b0, 1'b0, 8'd0,   1'b0, MODE_ONE, 1'b0)  // no press is short
        };
        prev_write = 1'b0;
        foreach (directed[n]) begin
            if (directed[n].is_write) begin
                // a run of writes only once the block has gone quiet
                if (!prev_write)
                    settle();
                write_reg(directed[n].idx, directed[n].value);
            end else begin
                send_tick(directed[n].key, directed[n].lock, directed[n].sound,
                          directed[n].typed, directed[n].want);
            end
            prev_write = directed[n].is_write;
        end

        // random gesture phases, each under its own register settings
        plan = '{PH_LIVELY, PH_BURST, PH_WIDE, PH_NO_WINDOW};
        foreach (plan[p]) begin
            settle();
            write_settings(phase_settings(plan[p]));
            src_gaps    = plan[p] != PH_BURST;
            sink_stalls = plan[p] != PH_BURST;
            phase_end   = ticks_sent + 100;
            while (ticks_sent < phase_end)
                key_gesture();
        end

        // blink soak: long enough in mode 6 for the fast pulse counter to wrap,
        // then a stretch of the slow on phase in mode 5
        settle();
        write_settings(phase_settings(PH_BLINK));
        steer_to(MODE_FAST);
        dwell(600);
        steer_to(MODE_SLOW);
        dwell(150);

        // let the last results drain, bounded
        tick_ch.valid <= 1'b0;
        for (int w = 0; w < 1000 && pending_results.size() != 0; w++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (error_count == 0)
            $display("PASS key_mode_power_controller");
        else
            $display("FAIL key_mode_power_controller");
        $finish;
    end

endmodule

[key_mode_power_controller.f]
hdl/kmpc_pkg.sv
hdl/kmpc_if.sv
hdl/kmpc_step.sv
hdl/key_mode_power_controller.sv
dv/key_mode_power_controller_tb.sv
